FILE: hdl/dns_answer_ipv4_extractor_core_defines.svh
// ----------------------------------------------------------------------------
// dns_answer_ipv4_extractor_core_defines.svh
// Assertion macros used by the checker file.
// ----------------------------------------------------------------------------
`ifndef DNS_ANSWER_IPV4_EXTRACTOR_CORE_DEFINES_SVH
`define DNS_ANSWER_IPV4_EXTRACTOR_CORE_DEFINES_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define DAE_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dae check failed");

// next-cycle implication, sampled on clk, off while rst_n is low
`define DAE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dae check failed");

`endif

FILE: hdl/dae_pkg.sv
// ----------------------------------------------------------------------------
// dae_pkg
// Types and fixed constants of the DNS answer IPv4 extractor.
// ----------------------------------------------------------------------------
package dae_pkg;

    localparam int HEADER_LAST = 11;   // last offset of the fixed header
    localparam int QTAIL_LEN   = 5;    // terminating zero + qtype + qclass
    localparam int RR_HDR_LEN  = 12;   // name ptr, type, class, ttl, rdlength
    localparam int COUNT_W     = 7;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic [15:0] packet_length;
        logic        end_of_packet;
    } in_t;

    typedef struct packed {
        logic               result_kind;
        logic [31:0]        ipv4_address;
        logic [COUNT_W-1:0] address_count;
        logic               last_result;
    } res_t;

    typedef struct packed {
        logic [1:0] n;
        res_t       r0;
        res_t       r1;
    } push_t;

    localparam logic KIND_ADDRESS = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

endpackage

FILE: hdl/dae_in_if.sv
// ----------------------------------------------------------------------------
// dae_in_if
// Byte channel into the extractor.
// ----------------------------------------------------------------------------
interface dae_in_if;
    logic        valid;
    logic        ready;
    logic [7:0]  data_byte;
    logic [15:0] packet_length;
    logic        end_of_packet;

    modport source (output valid, output data_byte, output packet_length,
                    output end_of_packet, input ready);
    modport sink (input valid, input data_byte, input packet_length,
                  input end_of_packet, output ready);
endinterface

FILE: hdl/dae_out_if.sv
// ----------------------------------------------------------------------------
// dae_out_if
// Result channel out of the extractor.
// ----------------------------------------------------------------------------
interface dae_out_if;
    logic        valid;
    logic        ready;
    logic        result_kind;
    logic [31:0] ipv4_address;
    logic [6:0]  address_count;
    logic        last_result;

    modport source (output valid, output result_kind, output ipv4_address,
                    output address_count, output last_result, input ready);
    modport sink (input valid, input result_kind, input ipv4_address,
                  input address_count, input last_result, output ready);
endinterface

FILE: hdl/dns_answer_ipv4_extractor_core.sv
// ----------------------------------------------------------------------------
// dns_answer_ipv4_extractor_core
// Streams a DNS response byte by byte and reports its A-record addresses.
// ----------------------------------------------------------------------------
// Usage:
//   pkt carries one message byte per item with the packet length and an
//   end-of-packet flag. res carries address items (result_kind 0) and one
//   summary item (result_kind 1, last_result 1) per packet.
//   One byte is taken per cycle while pkt.ready is high. With the queue
//   empty, an item's first result shows on res in the following cycle;
//   later results queue behind it. The final address byte, when it also
//   ends the packet, yields two results, which leave one after the other.
//   Results sit in a four-entry queue. pkt.ready is high while the queue
//   has room for two more results, so a stalled res fills the queue and
//   then holds off pkt; with res.ready high, ready stays high every cycle.
//   Reset empties the queue and returns the parser to the header of a new
//   packet; end_of_packet returns the parser to the header after its summary.
//   MAX_ADDRESSES caps the addresses reported per packet.
// ----------------------------------------------------------------------------
module dns_answer_ipv4_extractor_core
    import dae_pkg::*;
#(
    parameter int MAX_ADDRESSES = 64
)
(
    input logic      clk,
    input logic      rst_n,
    dae_in_if.sink   pkt,
    dae_out_if.source res
);

    logic  accept;
    logic  space_ok;
    logic  head_valid;
    in_t   item;
    res_t  head;
    push_t push;

    assign pkt.ready = space_ok;
    assign accept    = pkt.valid && space_ok;

    assign item.data_byte     = pkt.data_byte;
    assign item.packet_length = pkt.packet_length;
    assign item.end_of_packet = pkt.end_of_packet;

    dae_parser #(
        .MAX_ADDRESSES (MAX_ADDRESSES)
    ) u_parser (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .item   (item),
        .push   (push)
    );

    dae_outq u_outq (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .pop        (head_valid && res.ready),
        .space_ok   (space_ok),
        .head_valid (head_valid),
        .head       (head)
    );

    assign res.valid         = head_valid;
    assign res.result_kind   = head.result_kind;
    assign res.ipv4_address  = head.ipv4_address;
    assign res.address_count = head.address_count;
    assign res.last_result   = head.last_result;

endmodule

FILE: hdl/dae_parser.sv
// ----------------------------------------------------------------------------
// dae_parser
// Per-byte DNS response parser: state update and result generation.
// ----------------------------------------------------------------------------
module dae_parser
    import dae_pkg::*;
#(
    parameter int MAX_ADDRESSES = 64
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  accept,
    input  in_t   item,
    output push_t push
);

    localparam int CW = $clog2(MAX_ADDRESSES + 1);
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_ADDRESSES);

    localparam logic [2:0] PH_HEADER   = 3'd0;
    localparam logic [2:0] PH_QUESTION = 3'd1;
    localparam logic [2:0] PH_WAIT     = 3'd2;
    localparam logic [2:0] PH_RECORD   = 3'd3;
    localparam logic [2:0] PH_ADDRESS  = 3'd4;
    localparam logic [2:0] PH_STOPPED  = 3'd5;

    logic [2:0]    phase_reg, phase_next;
    logic [15:0]   off_reg, off_next;
    logic [16:0]   nb_reg, nb_next;
    logic [15:0]   type_reg, type_next;
    logic [15:0]   class_reg, class_next;
    logic [15:0]   dlen_reg, dlen_next;
    logic [23:0]   shift_reg, shift_next;
    logic [CW-1:0] cnt_reg, cnt_next;

    logic [2:0]       ph;
    logic [16:0]      off17;
    logic [16:0]      rel;
    logic [15:0]      dlen_full;
    logic [CW-1:0]    cnt_upd;
    logic [CW+6:0]    cnt_ext;
    logic             emit_addr;
    logic [31:0]      addr;
    res_t             r_addr;
    res_t             r_sum;

    always_comb
    begin
        ph         = phase_reg;
        off17      = {1'b0, off_reg};
        rel        = off17 - nb_reg;
        dlen_full  = {dlen_reg[15:8], item.data_byte};
        addr       = {shift_reg, item.data_byte};
        cnt_upd    = cnt_reg;
        emit_addr  = 1'b0;
        nb_next    = nb_reg;
        type_next  = type_reg;
        class_next = class_reg;
        dlen_next  = dlen_reg;
        shift_next = shift_reg;
        off_next   = off_reg;

        if (ph == PH_WAIT && off17 == nb_reg)
        begin
            if ({1'b0, nb_reg} + 18'(RR_HDR_LEN) > {2'b0, item.packet_length})
                ph = PH_STOPPED;
            else
                ph = PH_RECORD;
        end

        case (ph)
            PH_HEADER:
            begin
                if (off_reg >= 16'(HEADER_LAST))
                    ph = PH_QUESTION;
            end
            PH_QUESTION:
            begin
                if (off_reg >= item.packet_length)
                    ph = PH_STOPPED;
                else if (item.data_byte == 8'h00)
                begin
                    if (off17 + 17'(QTAIL_LEN) > {1'b0, item.packet_length})
                        ph = PH_STOPPED;
                    else
                    begin
                        nb_next = off17 + 17'(QTAIL_LEN);
                        ph      = PH_WAIT;
                    end
                end
            end
            PH_RECORD:
            begin
                case (rel)
                    17'd2:  type_next  = {item.data_byte, 8'h00};
                    17'd3:  type_next  = {type_reg[15:8], item.data_byte};
                    17'd4:  class_next = {item.data_byte, 8'h00};
                    17'd5:  class_next = {class_reg[15:8], item.data_byte};
                    17'd10: dlen_next  = {item.data_byte, 8'h00};
                    17'd11:
                    begin
                        dlen_next = dlen_full;
                        if (type_reg == 16'd1 && class_reg == 16'd1 && dlen_full == 16'd4)
                        begin
                            if (off17 + 17'd5 > {1'b0, item.packet_length})
                                ph = PH_STOPPED;
                            else
                            begin
                                nb_next = off17 + 17'd1;
                                ph      = PH_ADDRESS;
                            end
                        end
                        else
                        begin
                            nb_next = off17 + 17'd1 + {1'b0, dlen_full};
                            ph      = PH_WAIT;
                        end
                    end
                    default: ;
                endcase
            end
            PH_ADDRESS:
            begin
                if (rel < 17'd3)
                    shift_next = {shift_reg[15:0], item.data_byte};
                else if (cnt_reg >= MAX_CNT)
                    ph = PH_STOPPED;
                else
                begin
                    cnt_upd   = cnt_reg + 1'b1;
                    emit_addr = 1'b1;
                    nb_next   = off17 + 17'd1;
                    ph        = PH_WAIT;
                end
            end
            default: ;
        endcase

        cnt_next   = cnt_upd;
        phase_next = ph;

        if (item.end_of_packet)
        begin
            phase_next = PH_HEADER;
            off_next   = '0;
            nb_next    = '0;
            type_next  = '0;
            class_next = '0;
            dlen_next  = '0;
            shift_next = '0;
            cnt_next   = '0;
        end
        else if (off_reg == 16'hFFFF)
            phase_next = PH_STOPPED;
        else
            off_next = off_reg + 16'd1;
    end

    // count is reported modulo 128
    assign cnt_ext = {7'd0, cnt_upd};

    always_comb
    begin
        r_addr.result_kind   = KIND_ADDRESS;
        r_addr.ipv4_address  = addr;
        r_addr.address_count = cnt_ext[COUNT_W-1:0];
        r_addr.last_result   = 1'b0;
        r_sum.result_kind    = KIND_SUMMARY;
        r_sum.ipv4_address   = '0;
        r_sum.address_count  = cnt_ext[COUNT_W-1:0];
        r_sum.last_result    = 1'b1;

        push.r0 = emit_addr ? r_addr : r_sum;
        push.r1 = r_sum;
        if (!accept)
            push.n = 2'd0;
        else
            push.n = 2'(emit_addr) + 2'(item.end_of_packet);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HEADER;
            off_reg   <= '0;
            nb_reg    <= '0;
            type_reg  <= '0;
            class_reg <= '0;
            dlen_reg  <= '0;
            shift_reg <= '0;
            cnt_reg   <= '0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            off_reg   <= off_next;
            nb_reg    <= nb_next;
            type_reg  <= type_next;
            class_reg <= class_next;
            dlen_reg  <= dlen_next;
            shift_reg <= shift_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

FILE: hdl/dae_outq.sv
// ----------------------------------------------------------------------------
// dae_outq
// Four-entry result queue; takes up to two results per cycle, gives one.
// ----------------------------------------------------------------------------
module dae_outq
    import dae_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  push_t push,
    input  logic  pop,
    output logic  space_ok,
    output logic  head_valid,
    output res_t  head
);

    res_t       q_reg [4];
    logic [1:0] wr_reg, wr_next;
    logic [1:0] rd_reg, rd_next;
    logic [2:0] cnt_reg, cnt_next;

    assign wr_next  = wr_reg + push.n;
    assign rd_next  = rd_reg + 2'(pop);
    assign cnt_next = cnt_reg + 3'(push.n) - 3'(pop);

    // room for the worst case of two results from one item
    assign space_ok   = (cnt_reg <= 3'd2);
    assign head_valid = (cnt_reg != 3'd0);
    assign head       = q_reg[rd_reg];

    always_ff @(posedge clk)
    begin
        if (push.n != 2'd0)
            q_reg[wr_reg] <= push.r0;
        if (push.n == 2'd2)
            q_reg[wr_reg + 2'd1] <= push.r1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

FILE: hdl/dae_checker.sv
// ----------------------------------------------------------------------------
// dae_checker
// Port-level checks of the extractor, bound to the top level.
// ----------------------------------------------------------------------------
`include "dns_answer_ipv4_extractor_core_defines.svh"

module dae_checker
    import dae_pkg::*;
#(
    parameter int MAX_ADDRESSES = 64
)
(
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic        result_kind,
    input logic [31:0] ipv4_address,
    input logic [6:0]  address_count,
    input logic        last_result
);

    localparam logic WIDE_LIMIT = (MAX_ADDRESSES > 127);

    `DAE_ASSERT_SAME(a_summary_form, out_valid && result_kind == KIND_SUMMARY, last_result && ipv4_address == 32'd0)

    `DAE_ASSERT_SAME(a_address_form, out_valid && result_kind == KIND_ADDRESS, !last_result && (address_count != 7'd0 || WIDE_LIMIT))

    `DAE_ASSERT_SAME(a_count_limit, out_valid, WIDE_LIMIT || 32'(address_count) <= 32'(MAX_ADDRESSES))

    `DAE_ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid && $stable(result_kind) && $stable(ipv4_address) && $stable(address_count) && $stable(last_result))

endmodule

bind dns_answer_ipv4_extractor_core dae_checker #(
    .MAX_ADDRESSES (MAX_ADDRESSES)
) u_dae_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (res.valid),
    .out_ready     (res.ready),
    .result_kind   (res.result_kind),
    .ipv4_address  (res.ipv4_address),
    .address_count (res.address_count),
    .last_result   (res.last_result)
);

FILE: verif/dns_answer_ipv4_extractor_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dns_answer_ipv4_extractor_core_tb
// Self-checking bench for the DNS answer IPv4 extractor. A short table of
// bytes hits the short-packet and question-overrun paths. Random DNS
// responses follow, mostly well formed with random content, mixed with
// truncated, cut-off, varying-length and noise packets, and one packet past
// the address cap. Every result is checked against an in-bench model of the
// parser, under three idle patterns on both channels.
// ----------------------------------------------------------------------------
module dns_answer_ipv4_extractor_core_tb;
    import dae_pkg::*;

    localparam int          ADDR_CAP    = 64;
    localparam logic [15:0] RR_TYPE_A   = 16'd1;
    localparam logic [15:0] RR_CLASS_IN = 16'd1;
    localparam logic [15:0] A_RDLEN     = 16'd4;
    localparam int          ITEMS_PER_PHASE = 70;

    localparam res_t NO_RESULT     = '0;
    localparam res_t EMPTY_SUMMARY = '{KIND_SUMMARY, 32'h0, 7'd0, 1'b1};

    typedef enum logic [2:0]
    {
        SCAN_HEADER,
        SCAN_QUESTION,
        SCAN_WAIT,
        SCAN_RECORD,
        SCAN_ADDRESS,
        SCAN_STOPPED
    } scan_phase_e;

    typedef struct packed
    {
        in_t  item;
        logic typed;
        res_t want;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n;

    dae_in_if  pkt_if ();
    dae_out_if res_if ();

    dns_answer_ipv4_extractor_core #(
        .MAX_ADDRESSES (ADDR_CAP)
    ) i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .pkt   (pkt_if),
        .res   (res_if)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // parser model state
    scan_phase_e scan_phase;
    logic [15:0] scan_offset;
    logic [16:0] rec_boundary;
    logic [15:0] rec_type;
    logic [15:0] rec_class;
    logic [15:0] rec_len;
    logic [23:0] addr_shift;
    int          addr_found;

    res_t        expected_q[$];
    logic [7:0]  frame[$];
    int          fail_count = 0;
    int          items_sent = 0;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    logic        typed_armed = 1'b0;
    res_t        typed_want = '0;

    // short packets and a question zero that overruns the length
    stim_row_t directed_rows [0:19] = '{
        '{'{8'h00, 16'd0,     1'b1}, 1'b1, EMPTY_SUMMARY},
        '{'{8'hFF, 16'hFFFF,  1'b1}, 1'b1, EMPTY_SUMMARY},
        '{'{8'hFF, 16'd5,     1'b0}, 1'b0, NO_RESULT},
        '{'{8'h00, 16'd5,     1'b0}, 1'b0, NO_RESULT},
        '{'{8'hFF, 16'd5,     1'b0}, 1'b0, NO_RESULT},
        '{'{8'h00, 16'd5,     1'b0}, 1'b0, NO_RESULT},
        '{'{8'hFF, 16'd5,     1'b1}, 1'b1, EMPTY_SUMMARY},
        '{'{8'hFF, 16'd13,    1'b0}, 1'b0, NO_RESULT},
        '{'{8'h00, 16'd13,    1'b0}, 1'b0, NO_RESULT},
        '{'{8'hFF, 16'd13,    1'b0}, 1'b0, NO_RESULT},
        '{'{8'h00, 16'd13,    1'b0}, 1'b0, NO_RESULT},
        '{'{8'hFF, 16'd13,    1'b0}, 1'b0, NO_RESULT},
        '{'{8'h00, 16'd13,    1'b0}, 1'b0, NO_RESULT},
        '{'{8'hFF, 16'd13,    1'b0}, 1'b0, NO_RESULT},
        '{'{8'h00, 16'd13,    1'b0}, 1'b0, NO_RESULT},
        '{'{8'hFF, 16'd13,    1'b0}, 1'b0, NO_RESULT},
        '{'{8'h00, 16'd13,    1'b0}, 1'b0, NO_RESULT},
        '{'{8'hFF, 16'd13,    1'b0}, 1'b0, NO_RESULT},
        '{'{8'h00, 16'd13,    1'b0}, 1'b0, NO_RESULT},
        '{'{8'h00, 16'd13,    1'b1}, 1'b1, EMPTY_SUMMARY}
    };

    task automatic clear_scan_state();
        scan_phase   = SCAN_HEADER;
        scan_offset  = '0;
        rec_boundary = '0;
        rec_type     = '0;
        rec_class    = '0;
        rec_len      = '0;
        addr_shift   = '0;
        addr_found   = 0;
    endtask

    task automatic extract_step(input in_t it);
        int          off;
        int          len;
        int          rel;
        logic [7:0]  b;
        logic [31:0] addr;
        off = int'(scan_offset);
        len = int'(it.packet_length);
        b   = it.data_byte;

        if (scan_phase == SCAN_WAIT && off == int'(rec_boundary))
            scan_phase = (int'(rec_boundary) + RR_HDR_LEN > len) ? SCAN_STOPPED : SCAN_RECORD;

        case (scan_phase)
            SCAN_HEADER:
            begin
                if (off >= HEADER_LAST)
                    scan_phase = SCAN_QUESTION;
            end
            SCAN_QUESTION:
            begin
                if (off >= len)
                    scan_phase = SCAN_STOPPED;
                else if (b == 8'h00)
                begin
                    if (off + QTAIL_LEN > len)
                        scan_phase = SCAN_STOPPED;
                    else
                    begin
                        rec_boundary = 17'(off + QTAIL_LEN);
                        scan_phase   = SCAN_WAIT;
                    end
                end
            end
            SCAN_RECORD:
            begin
                rel = (off - int'(rec_boundary)) & 32'h1FFFF;
                case (rel)
                    2:  rec_type  = {b, 8'h00};
                    3:  rec_type  = rec_type | 16'(b);
                    4:  rec_class = {b, 8'h00};
                    5:  rec_class = rec_class | 16'(b);
                    10: rec_len   = {b, 8'h00};
                    11:
                    begin
                        rec_len = rec_len | 16'(b);
                        if (rec_type == RR_TYPE_A && rec_class == RR_CLASS_IN
                            && rec_len == A_RDLEN)
                        begin
                            if (off + 5 > len)
                                scan_phase = SCAN_STOPPED;
                            else
                            begin
                                rec_boundary = 17'(off + 1);
                                scan_phase   = SCAN_ADDRESS;
                            end
                        end
                        else
                        begin
                            rec_boundary = 17'(off + 1 + int'(rec_len));
                            scan_phase   = SCAN_WAIT;
                        end
                    end
                    default: ;
                endcase
            end
            SCAN_ADDRESS:
            begin
                rel = (off - int'(rec_boundary)) & 32'h1FFFF;
                if (rel < 3)
                    addr_shift = {addr_shift[15:0], b};
                else
                begin
                    addr = {addr_shift, b};
                    if (addr_found >= ADDR_CAP)
                        scan_phase = SCAN_STOPPED;
                    else
                    begin
                        addr_found++;
                        expected_q.push_back('{KIND_ADDRESS, addr, 7'(addr_found), 1'b0});
                        rec_boundary = 17'(off + 1);
                        scan_phase   = SCAN_WAIT;
                    end
                end
            end
            default: ;
        endcase

        if (it.end_of_packet)
        begin
            expected_q.push_back('{KIND_SUMMARY, 32'h0, 7'(addr_found), 1'b1});
            clear_scan_state();
        end
        else if (off >= 32'hFFFF)
            scan_phase = SCAN_STOPPED;
        else
            scan_offset = 16'(off + 1);
    endtask

    function automatic void compare_field(input string name, input logic [31:0] want,
                                          input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
            fail_count++;
        end
    endfunction

    task automatic check_result();
        res_t want;
        if (expected_q.size() == 0)
        begin
            $display("%0t: unexpected result, expected none actual kind %0d addr %h count %0d",
                     $time, res_if.result_kind, res_if.ipv4_address, res_if.address_count);
            fail_count++;
        end
        else
        begin
            want = expected_q.pop_front();
            compare_field("result_kind", 32'(want.result_kind), 32'(res_if.result_kind));
            compare_field("ipv4_address", want.ipv4_address, res_if.ipv4_address);
            compare_field("address_count", 32'(want.address_count), 32'(res_if.address_count));
            compare_field("last_result", 32'(want.last_result), 32'(res_if.last_result));
        end
    endtask

    always @(posedge clk)
    begin : scoreboard
        int mark;
        if (rst_n)
        begin
            if (res_if.valid && res_if.ready)
                check_result();
            if (pkt_if.valid && pkt_if.ready)
            begin
                mark = expected_q.size();
                extract_step('{pkt_if.data_byte, pkt_if.packet_length, pkt_if.end_of_packet});
                if (typed_armed)
                begin
                    while (expected_q.size() > mark)
                        void'(expected_q.pop_back());
                    expected_q.push_back(typed_want);
                end
            end
        end
    end

    initial
        res_if.ready = 1'b0;

    always @(negedge clk)
        res_if.ready <= ($urandom_range(99) >= recv_idle_pct);

    task automatic send_item(input in_t it, input logic typed, input res_t want);
        while ($urandom_range(99) < send_idle_pct)
        begin
            pkt_if.valid <= 1'b0;
            @(negedge clk);
        end
        typed_armed = typed;
        typed_want  = want;
        pkt_if.valid         <= 1'b1;
        pkt_if.data_byte     <= it.data_byte;
        pkt_if.packet_length <= it.packet_length;
        pkt_if.end_of_packet <= it.end_of_packet;
        do
            @(posedge clk);
        while (!pkt_if.ready);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic drain_results();
        pkt_if.valid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic push_rand(input int n);
        repeat (n)
            frame.push_back(8'($urandom_range(255)));
    endtask

    task automatic push_word(input logic [15:0] w);
        frame.push_back(w[15:8]);
        frame.push_back(w[7:0]);
    endtask

    task automatic add_record(input logic a_rec, input int payload_len);
        logic [15:0] t;
        logic [15:0] c;
        t = 16'($urandom_range(65535));
        c = 16'($urandom_range(65535));
        if (a_rec)
        begin
            t = RR_TYPE_A;
            c = RR_CLASS_IN;
            payload_len = A_RDLEN;
        end
        else
        begin
            case ($urandom_range(3))
                0: t = RR_TYPE_A;
                1: c = RR_CLASS_IN;
                2:
                begin
                    t = RR_TYPE_A;
                    c = RR_CLASS_IN;
                    if (payload_len == A_RDLEN)
                        payload_len++;
                end
                default: ;
            endcase
        end
        push_rand(2);
        push_word(t);
        push_word(c);
        push_rand(4);
        push_word(16'(payload_len));
        push_rand(payload_len);
    endtask

    task automatic build_answer(input int n_rec, input int a_pct);
        int n_lab;
        int lab_len;
        frame.delete();
        push_rand(12);
        n_lab = $urandom_range(0, 3);
        repeat (n_lab)
        begin
            lab_len = $urandom_range(1, 6);
            frame.push_back(8'(lab_len));
            repeat (lab_len)
                frame.push_back(8'($urandom_range(1, 255)));
        end
        frame.push_back(8'h00);
        push_rand(4);
        repeat (n_rec)
            add_record($urandom_range(99) < a_pct, $urandom_range(0, 8));
    endtask

    task automatic send_frame(input int len_field, input logic vary_len);
        in_t it;
        for (int i = 0; i < frame.size(); i++)
        begin
            it.data_byte     = frame[i];
            it.packet_length = (vary_len && $urandom_range(3) == 0) ?
                               16'($urandom_range(65535)) : 16'(len_field);
            it.end_of_packet = (i == frame.size() - 1);
            send_item(it, 1'b0, NO_RESULT);
        end
    endtask

    task automatic send_random_packet();
        int roll;
        int len_field;
        roll = $urandom_range(99);
        if (roll < 90)
            build_answer($urandom_range(0, 4), 75);
        len_field = frame.size();
        if (roll < 60)
            send_frame(len_field, 1'b0);
        else if (roll < 70)
        begin
            // length field off from the byte count: record and address overruns
            if ($urandom_range(1))
                len_field = frame.size() - $urandom_range(1, 8);
            else
                len_field = frame.size() + $urandom_range(0, 20);
            if (len_field < 0)
                len_field = 0;
            send_frame(len_field, 1'b0);
        end
        else if (roll < 78)
        begin
            // end of packet before the full message
            repeat ($urandom_range(1, 10))
                if (frame.size() > 1)
                    void'(frame.pop_back());
            send_frame(len_field, 1'b0);
        end
        else if (roll < 90)
            send_frame(len_field, 1'b1);
        else
        begin
            frame.delete();
            repeat ($urandom_range(1, 30))
                frame.push_back(($urandom_range(3) == 0) ? 8'h00 : 8'($urandom_range(255)));
            len_field = $urandom_range(1) ? $urandom_range(65535) : $urandom_range(0, 40);
            send_frame(len_field, 1'b0);
        end
    endtask

    initial
    begin
        int  goal;
        rst_n                = 1'b0;
        pkt_if.valid         = 1'b0;
        pkt_if.data_byte     = '0;
        pkt_if.packet_length = '0;
        pkt_if.end_of_packet = 1'b0;
        clear_scan_state();
        send_idle_pct = 31;
        recv_idle_pct = 75;
        repeat (5)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed_rows[i])
            send_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);

        for (int phase = 0; phase < 3; phase++)
        begin
            send_idle_pct = (phase == 0) ? 31 : (phase == 1) ? 75 : 0;
            recv_idle_pct = (phase == 0) ? 75 : (phase == 1) ? 31 : 0;
            goal = items_sent + ITEMS_PER_PHASE;
            while (items_sent < goal)
                send_random_packet();
            if (phase == 0)
                drain_results();
        end

        // more A records than the cap allows
        build_answer(ADDR_CAP + 2, 100);
        send_frame(frame.size(), 1'b0);

        drain_results();
        repeat (20)
            @(posedge clk);
        if (fail_count == 0 && expected_q.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("%0t: timeout, %0d results still expected", $time, expected_q.size());
        $display("Regression FAIL");
        $finish;
    end

endmodule

FILE: dns_answer_ipv4_extractor_core.f
+incdir+hdl
hdl/dae_pkg.sv
hdl/dae_in_if.sv
hdl/dae_out_if.sv
hdl/dae_parser.sv
hdl/dae_outq.sv
hdl/dns_answer_ipv4_extractor_core.sv
hdl/dae_checker.sv
verif/dns_answer_ipv4_extractor_core_tb.sv
